[rtl/core/pect_pkg.sv]
// ----------------------------------------------------------------------------
// pect_pkg: shared types and constants of the pointer event cursor tracker.
// Event and notice codes, fixed point widths and the reciprocal used to
// divide by the absolute full scale.
// ----------------------------------------------------------------------------
package pect_pkg;

   // Field widths.
   localparam int KIND_W  = 2;
   localparam int CODE_W  = 2;
   localparam int VALUE_W = 16;
   localparam int EXT_W   = 12;
   localparam int FRAC_W  = 8;
   localparam int POS_W   = EXT_W + FRAC_W;
   localparam int VEL_W   = 25;
   localparam int BTN_W   = 2;
   localparam int NOTE_W  = 3;

   // Absolute readings run from zero to this full scale.
   localparam int ABS_FULL_SCALE = 4095;
   localparam int ABS_W          = $clog2(ABS_FULL_SCALE + 1);

   // Scaling: q = floor(a * extent * 256 / ABS_FULL_SCALE).
   localparam int PROD_W   = ABS_W + EXT_W;
   localparam int NUM_W    = PROD_W + FRAC_W;
   localparam int RECIP_SH = NUM_W;
   localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / ABS_FULL_SCALE;
   localparam int RECIP_W  = $clog2(RECIP + 1);
   localparam int QPROD_W  = PROD_W + RECIP_W;

   // Configuration register indexes and reset values.
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;
   localparam logic [EXT_W-1:0] WIDTH_RESET  = EXT_W'(320);
   localparam logic [EXT_W-1:0] HEIGHT_RESET = EXT_W'(240);
   localparam logic [POS_W-1:0] POS_X_RESET  = POS_W'(40960);
   localparam logic [POS_W-1:0] POS_Y_RESET  = POS_W'(30720);

   // Button codes of an input event.
   localparam logic [CODE_W-1:0] CODE_LEFT   = 2'd0;
   localparam logic [CODE_W-1:0] CODE_RIGHT  = 2'd1;
   localparam logic [CODE_W-1:0] CODE_MIDDLE = 2'd2;

   // Axis codes of a motion event.
   localparam logic [CODE_W-1:0] AXIS_X = 2'd0;
   localparam logic [CODE_W-1:0] AXIS_Y = 2'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_BUTTON   = 2'd0,
      KIND_RELATIVE = 2'd1,
      KIND_ABSOLUTE = 2'd2,
      KIND_OTHER    = 2'd3
   } kind_type;

   typedef enum logic [NOTE_W-1:0] {
      NOTE_NONE    = 3'd0,
      NOTE_RELEASE = 3'd1,
      NOTE_CLICK   = 3'd2,
      NOTE_DRAG    = 3'd3,
      NOTE_MOVE    = 3'd4
   } notice_type;

   typedef enum logic [BTN_W-1:0] {
      HELD_NONE   = 2'd0,
      HELD_LEFT   = 2'd1,
      HELD_RIGHT  = 2'd2,
      HELD_MIDDLE = 2'd3
   } button_type;

   // One pointer event as it travels down the pipeline.
   typedef struct packed {
      kind_type            kind;
      logic [CODE_W-1:0]   code;
      logic [VALUE_W-1:0]  value;
   } event_type;

   // An event together with its scaled absolute position.
   typedef struct packed {
      event_type           ev;
      logic [POS_W-1:0]    scaled;
   } scaled_type;

endpackage

[rtl/core/pect_abs_scale.sv]
// ----------------------------------------------------------------------------
// pect_abs_scale: absolute position scaling pipeline.
// Saturates the reading, multiplies by the viewport extent, then divides by
// the full scale with a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module pect_abs_scale
   import pect_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  event_type           in_ev,
   input  logic [EXT_W-1:0]    width,
   input  logic [EXT_W-1:0]    height,
   output logic                out_valid,
   input  logic                out_ready,
   output scaled_type          out_item
);

   logic                 s2_valid_ff, s3_valid_ff, s4_valid_ff;
   event_type            s2_ev_ff, s3_ev_ff;
   logic [PROD_W-1:0]    s2_prod_ff, s2_prod_in;
   logic [PROD_W-1:0]    s3_prod_ff;
   logic [POS_W-1:0]     s3_q_ff, s3_q_in;
   scaled_type           s4_item_ff, s4_item_in;
   logic                 ready2, ready3, ready4;

   logic [ABS_W-1:0]     v_sat;
   logic [ABS_W-1:0]     a_sel;
   logic [EXT_W-1:0]     ext_sel;
   logic [QPROD_W-1:0]   qprod;
   logic [NUM_W-1:0]     num;
   logic [NUM_W-1:0]     back;
   logic [NUM_W-1:0]     rem;

   // A stage may load when it is empty or its contents move on.
   assign ready4   = !s4_valid_ff || out_ready;
   assign ready3   = !s3_valid_ff || ready4;
   assign ready2   = !s2_valid_ff || ready3;
   assign in_ready = ready2;

   // Saturate the reading, invert it for Y, and multiply by the extent.
   always_comb begin
      if (in_ev.value[VALUE_W-1]) begin
         v_sat = '0;
      end else if (in_ev.value > VALUE_W'(ABS_FULL_SCALE)) begin
         v_sat = ABS_W'(ABS_FULL_SCALE);
      end else begin
         v_sat = in_ev.value[ABS_W-1:0];
      end
      if (in_ev.code == AXIS_Y) begin
         a_sel   = ABS_W'(ABS_FULL_SCALE) - v_sat;
         ext_sel = height;
      end else begin
         a_sel   = v_sat;
         ext_sel = width;
      end
      s2_prod_in = PROD_W'(a_sel) * PROD_W'(ext_sel);
   end

   // Estimate of the quotient; it is low by at most one.
   always_comb begin
      qprod   = QPROD_W'(s2_prod_ff) * QPROD_W'(RECIP);
      s3_q_in = qprod[RECIP_SH-FRAC_W +: POS_W];
   end

   // Correct the estimate by comparing the remainder with the full scale.
   always_comb begin
      num  = {s3_prod_ff, {FRAC_W{1'b0}}};
      back = NUM_W'(s3_q_ff) * NUM_W'(ABS_FULL_SCALE);
      rem  = num - back;
      s4_item_in.ev = s3_ev_ff;
      if (rem >= NUM_W'(ABS_FULL_SCALE)) begin
         s4_item_in.scaled = s3_q_ff + POS_W'(1);
      end else begin
         s4_item_in.scaled = s3_q_ff;
      end
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (ready2) s2_valid_ff <= in_valid;
         if (ready3) s3_valid_ff <= s2_valid_ff;
         if (ready4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (ready2 && in_valid) begin
         s2_ev_ff   <= in_ev;
         s2_prod_ff <= s2_prod_in;
      end
      if (ready3 && s2_valid_ff) begin
         s3_ev_ff   <= s2_ev_ff;
         s3_prod_ff <= s2_prod_ff;
         s3_q_ff    <= s3_q_in;
      end
      if (ready4 && s3_valid_ff) begin
         s4_item_ff <= s4_item_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_item  = s4_item_ff;

endmodule

[rtl/core/pect_cursor_state.sv]
// ----------------------------------------------------------------------------
// pect_cursor_state: cursor state update and result register.
// Applies one event to the held button and cursor position and registers
// the transaction that reports it.
// ----------------------------------------------------------------------------
module pect_cursor_state
   import pect_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  scaled_type          in_item,
   input  logic [EXT_W-1:0]    width,
   input  logic [EXT_W-1:0]    height,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [NOTE_W-1:0]   rsp_notice,
   output logic [POS_W-1:0]    rsp_cursor_x,
   output logic [POS_W-1:0]    rsp_cursor_y,
   output logic [VEL_W-1:0]    rsp_speed_x,
   output logic [VEL_W-1:0]    rsp_speed_y,
   output logic [BTN_W-1:0]    rsp_held_button
);

   localparam int SUM_W = VEL_W + 1;

   logic                 valid_ff;
   logic [POS_W-1:0]     pos_x_ff, pos_x_in;
   logic [POS_W-1:0]     pos_y_ff, pos_y_in;
   button_type           btn_ff, btn_in;
   notice_type           notice_ff, notice_in;
   logic [VEL_W-1:0]     vel_x_ff, vel_x_in;
   logic [VEL_W-1:0]     vel_y_ff, vel_y_in;
   logic                 update;

   button_type           btn_new;
   logic [VEL_W-1:0]     step;
   logic [VEL_W-1:0]     rel_x, rel_y;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic [SUM_W-1:0]     top_x, top_y;
   logic signed [POS_W:0] diff;
   notice_type           motion_note;

   assign in_ready = !valid_ff || rsp_ready;
   assign update   = in_ready && in_valid;

   // Clamp a signed sum into zero through the viewport bound.
   function automatic logic [POS_W-1:0] clamp_axis(
      input logic signed [SUM_W-1:0] sum,
      input logic [SUM_W-1:0]        top
   );
      logic [POS_W-1:0] res;
      if (sum[SUM_W-1]) begin
         res = '0;
      end else if (SUM_W'(sum) > top) begin
         res = top[POS_W-1:0];
      end else begin
         res = sum[POS_W-1:0];
      end
      return res;
   endfunction

   // Button decode: only a press of a known button selects it.
   always_comb begin
      btn_new = HELD_NONE;
      if (in_item.ev.value == VALUE_W'(1)) begin
         case (in_item.ev.code)
            CODE_LEFT:   btn_new = HELD_LEFT;
            CODE_RIGHT:  btn_new = HELD_RIGHT;
            CODE_MIDDLE: btn_new = HELD_MIDDLE;
            default:     btn_new = HELD_NONE;
         endcase
      end
   end

   // Relative step and the clamped sums on both axes.
   always_comb begin
      step  = {in_item.ev.value[VALUE_W-1], in_item.ev.value, {FRAC_W{1'b0}}};
      rel_x = (in_item.ev.code == AXIS_X) ? step : '0;
      rel_y = (in_item.ev.code == AXIS_Y) ? VEL_W'(-step) : '0;
      sum_x = $signed({{(SUM_W-POS_W){1'b0}}, pos_x_ff})
            + $signed({rel_x[VEL_W-1], rel_x});
      sum_y = $signed({{(SUM_W-POS_W){1'b0}}, pos_y_ff})
            + $signed({rel_y[VEL_W-1], rel_y});
      top_x = {{(SUM_W-POS_W){1'b0}}, width, {FRAC_W{1'b0}}};
      top_y = {{(SUM_W-POS_W){1'b0}}, height, {FRAC_W{1'b0}}};
   end

   // Next state for one event; velocity starts at zero every time.
   always_comb begin
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      btn_in      = btn_ff;
      notice_in   = NOTE_NONE;
      vel_x_in    = '0;
      vel_y_in    = '0;
      diff        = '0;
      motion_note = (btn_ff != HELD_NONE) ? NOTE_DRAG : NOTE_MOVE;
      case (in_item.ev.kind)
         KIND_BUTTON: begin
            if (btn_new != btn_ff) begin
               btn_in    = btn_new;
               notice_in = (btn_new == HELD_NONE) ? NOTE_RELEASE : NOTE_CLICK;
            end
         end
         KIND_RELATIVE: begin
            vel_x_in  = rel_x;
            vel_y_in  = rel_y;
            pos_x_in  = clamp_axis(sum_x, top_x);
            pos_y_in  = clamp_axis(sum_y, top_y);
            notice_in = motion_note;
         end
         KIND_ABSOLUTE: begin
            if (in_item.ev.code == AXIS_X) begin
               diff     = $signed({1'b0, in_item.scaled}) - $signed({1'b0, pos_x_ff});
               vel_x_in = {{(VEL_W-POS_W-1){diff[POS_W]}}, diff};
               pos_x_in = in_item.scaled;
            end else if (in_item.ev.code == AXIS_Y) begin
               diff     = $signed({1'b0, in_item.scaled}) - $signed({1'b0, pos_y_ff});
               vel_y_in = {{(VEL_W-POS_W-1){diff[POS_W]}}, diff};
               pos_y_in = in_item.scaled;
            end
            notice_in = motion_note;
         end
         default: begin
            notice_in = NOTE_NONE;
         end
      endcase
   end

   // Cursor state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_x_ff <= POS_X_RESET;
         pos_y_ff <= POS_Y_RESET;
         btn_ff   <= HELD_NONE;
      end else begin
         if (in_ready) valid_ff <= in_valid;
         if (update) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            btn_ff   <= btn_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (update) begin
         notice_ff <= notice_in;
         vel_x_ff  <= vel_x_in;
         vel_y_ff  <= vel_y_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_notice      = notice_ff;
   assign rsp_cursor_x    = pos_x_ff;
   assign rsp_cursor_y    = pos_y_ff;
   assign rsp_speed_x     = vel_x_ff;
   assign rsp_speed_y     = vel_y_ff;
   assign rsp_held_button = btn_ff;

endmodule

[rtl/core/pointer_event_cursor_tracker.sv]
// ----------------------------------------------------------------------------
// pointer_event_cursor_tracker: cursor position, velocity and button tracker.
// A request passes the input register, the scaling stages and the result
// register. Throughput: one transaction per cycle while no result is held;
// each of the five register stages loads while it hands its contents on.
// Reset: synchronous; cursor to 160.0/120.0, viewport 320x240, no button.
// ----------------------------------------------------------------------------
module pointer_event_cursor_tracker
   import pect_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [CODE_W-1:0]   req_code,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [NOTE_W-1:0]   rsp_notice,
   output logic [POS_W-1:0]    rsp_cursor_x,
   output logic [POS_W-1:0]    rsp_cursor_y,
   output logic [VEL_W-1:0]    rsp_speed_x,
   output logic [VEL_W-1:0]    rsp_speed_y,
   output logic [BTN_W-1:0]    rsp_held_button,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [EXT_W-1:0]    csr_data
);

   logic [EXT_W-1:0]     width_ff, height_ff;
   logic                 s1_valid_ff;
   event_type            s1_ev_ff, s1_ev_in;
   logic                 scale_ready;
   logic                 scale_valid;
   scaled_type           scale_item;
   logic                 state_ready;

   // Viewport configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   // Input register stage.
   assign req_ready = !s1_valid_ff || scale_ready;

   always_comb begin
      s1_ev_in.kind  = kind_type'(req_kind);
      s1_ev_in.code  = req_code;
      s1_ev_in.value = req_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_ev_ff <= s1_ev_in;
      end
   end

   // Absolute position scaling.
   pect_abs_scale u_abs_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (scale_ready),
      .in_ev     (s1_ev_ff),
      .width     (width_ff),
      .height    (height_ff),
      .out_valid (scale_valid),
      .out_ready (state_ready),
      .out_item  (scale_item)
   );

   // Cursor state update and result register.
   pect_cursor_state u_cursor_state (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (scale_valid),
      .in_ready        (state_ready),
      .in_item         (scale_item),
      .width           (width_ff),
      .height          (height_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_notice      (rsp_notice),
      .rsp_cursor_x    (rsp_cursor_x),
      .rsp_cursor_y    (rsp_cursor_y),
      .rsp_speed_x     (rsp_speed_x),
      .rsp_speed_y     (rsp_speed_y),
      .rsp_held_button (rsp_held_button)
   );

endmodule
